>>> src/two_class_age_ordered_fifo_defines.svh
// Assertion helpers shared by the queue and the top level
`ifndef TWO_CLASS_AGE_ORDERED_FIFO_DEFINES_SVH
`define TWO_CLASS_AGE_ORDERED_FIFO_DEFINES_SVH

// Check a property on every clock edge outside reset
`define TCAOF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define TCAOF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/tcaof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcaof_pkg;

  typedef enum logic [1:0] {
    TAKE_OLDEST      = 2'd0,
    TAKE_POSITIVE    = 2'd1,
    TAKE_NONPOSITIVE = 2'd2
  } take_kind_e;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

>>> src/two_class_age_ordered_fifo.sv
// Two-class age-ordered FIFO.
// Input channel (in_valid_i / in_ready_o) carries one item: action_i = 1
// enqueues item_value_i, stamped with the next arrival count; a positive
// value joins the positive queue, zero or negative the nonpositive queue.
// action_i = 0 dequeues per take_kind_i: oldest head of both queues,
// the positive queue, or the nonpositive queue (code 3 acts as nonpositive).
// Output channel (out_valid_o / out_ready_i) carries taken_value_o, sent
// only when a dequeue removes a nonzero value. Enqueues into a full queue,
// dequeues from an empty queue and dequeued zeros give no result.
// An accepted item is held in the input register; when it advances it is
// processed and its result is registered in the output register.
// Throughput: one item per cycle while no result waits; each queue keeps
// its head entry in a registered read port of its store, refilled every
// cycle with write forwarding, so back-to-back dequeues do not stall.
// Reset: both queues empty, arrival counter zero, no result pending.
// Stall: a waiting result holds; one more item is taken into the input
// register, then in_ready_o drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_age_ordered_fifo_defines.svh"

module two_class_age_ordered_fifo #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 16,
  parameter int STAMP_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic signed [VALUE_WIDTH-1:0] item_value_i,
  input  wire logic        [1:0]             take_kind_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed      [VALUE_WIDTH-1:0] taken_value_o
);

  localparam int EW = VALUE_WIDTH + STAMP_WIDTH;

  logic                   s1_valid_q;
  logic                   s1_action_q;
  logic [VALUE_WIDTH-1:0] s1_value_q;
  logic [1:0]             s1_kind_q;
  logic                   s1_advance;

  logic [STAMP_WIDTH-1:0] stamp_q, stamp_d;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;

  tcaof_pkg::q_status_t   pos_status, neg_status;
  logic [EW-1:0]          pos_head, neg_head;
  logic [EW-1:0]          wdata;
  logic                   is_pos;
  logic                   push_pos, push_neg;
  logic                   pop_pos, pop_neg;
  logic                   take_pos;
  logic [STAMP_WIDTH-1:0] stamp_diff;
  logic [VALUE_WIDTH-1:0] got;
  logic                   emit;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_comb begin
    stamp_d    = stamp_q + 1'b1;
    wdata      = {s1_value_q, stamp_d};
    is_pos     = (s1_value_q != '0) && !s1_value_q[VALUE_WIDTH-1];
    push_pos   = s1_advance && s1_action_q && is_pos && !pos_status.full;
    push_neg   = s1_advance && s1_action_q && !is_pos && !neg_status.full;
    stamp_diff = pos_head[STAMP_WIDTH-1:0] - neg_head[STAMP_WIDTH-1:0];
    case (s1_kind_q)
      tcaof_pkg::TAKE_OLDEST: begin
        if (pos_status.empty) begin
          take_pos = 1'b0;
        end else if (neg_status.empty) begin
          take_pos = 1'b1;
        end else begin
          take_pos = stamp_diff[STAMP_WIDTH-1];
        end
      end
      tcaof_pkg::TAKE_POSITIVE: take_pos = 1'b1;
      default:                  take_pos = 1'b0;
    endcase
    pop_pos = s1_advance && !s1_action_q && take_pos && !pos_status.empty;
    pop_neg = s1_advance && !s1_action_q && !take_pos && !neg_status.empty;
    got     = pop_pos ? pos_head[EW-1:STAMP_WIDTH] : neg_head[EW-1:STAMP_WIDTH];
    emit    = (pop_pos || pop_neg) && (got != '0);
  end

  tcaof_queue #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_pos_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_pos),
    .wdata_i (wdata),
    .pop_i   (pop_pos),
    .status_o(pos_status),
    .head_o  (pos_head)
  );

  tcaof_queue #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_neg_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_neg),
    .wdata_i (wdata),
    .pop_i   (pop_neg),
    .status_o(neg_status),
    .head_o  (neg_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance && s1_action_q) begin
        stamp_q <= stamp_d;
      end
      if (s1_advance) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_action_q <= action_i;
      s1_value_q  <= item_value_i;
      s1_kind_q   <= take_kind_i;
    end
    if (s1_advance && emit) begin
      out_value_q <= got;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign taken_value_o = out_value_q;

  `TCAOF_ASSERT(a_nonzero_out, out_valid_o |-> taken_value_o != '0, "zero value emitted")
  `TCAOF_ASSERT(a_single_op, $onehot0({push_pos, push_neg, pop_pos, pop_neg}),
                "more than one queue operation in a cycle")
  `TCAOF_ASSERT(a_stall_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(taken_value_o),
                "waiting result changed")

endmodule

`default_nettype wire

>>> src/tcaof_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_age_ordered_fifo_defines.svh"

module tcaof_queue #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic [WIDTH-1:0]        wdata_i,
  input  wire logic                    pop_i,
  output tcaof_pkg::q_status_t         status_o,
  output logic      [WIDTH-1:0]        head_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign head_o         = rd_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (pop_i) begin
      head_d = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (push_i) begin
      tail_d = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Write at the tail; read the next head, forwarding a same-cycle write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (push_i && (tail_q == head_d)) begin
      rd_q <= wdata_i;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  `TCAOF_ASSERT(a_no_pop_empty, pop_i |-> !status_o.empty, "pop from empty queue")
  `TCAOF_ASSERT(a_no_push_full, push_i && !pop_i |-> !status_o.full, "push into full queue")
  `TCAOF_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1,
                "count did not advance on push")
  `TCAOF_ASSERT(a_count_range, count_q <= CW'(DEPTH), "count beyond depth")

endmodule

`default_nettype wire
